// ===== rtl/rkm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RSA key derivation and exponentiation block.
// Depends on nothing; rsa_keygen_and_modexp uses it by scoped names.
package rkm_pkg;

  localparam int WORD_W    = 32;
  localparam int VALUE_W   = 32;
  localparam int RCNT_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q = 1'b1;

  typedef struct packed {
    logic               func;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic [WORD_W-1:0] public_exponent;
    logic [WORD_W-1:0] private_exponent;
    logic [WORD_W-1:0] modulus;
    logic              status;
  } out_word_t;

endpackage

// ===== rtl/rkm_mulmod.sv =====
`timescale 1ns / 1ps
// Bit-serial modular multiplier: prod = a * b mod n, one bit of b per double step and add step.
// Operands a and b must be below n. Depends on nothing else.
module rkm_mulmod #(
  parameter int MW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  input  logic [MW-1:0] n,
  output logic          done,
  output logic [MW-1:0] prod
);

  localparam int CW = $clog2(MW + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DBL, ST_ADD} state_t;

  state_t        state_r;
  logic [MW-1:0] acc_r, a_r, b_r, n_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [MW:0]   dbl_s, add_s, dbl_nxt, add_nxt;

  always_comb begin
    dbl_s   = {acc_r, 1'b0};
    dbl_nxt = (dbl_s >= {1'b0, n_r}) ? dbl_s - {1'b0, n_r} : dbl_s;
    add_s   = {1'b0, acc_r} + (b_r[MW-1] ? {1'b0, a_r} : '0);
    add_nxt = (add_s >= {1'b0, n_r}) ? add_s - {1'b0, n_r} : add_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            acc_r   <= '0;
            a_r     <= a;
            b_r     <= b;
            n_r     <= n;
            cnt_r   <= CW'(MW);
            state_r <= ST_DBL;
          end
        end
        ST_DBL: begin
          acc_r   <= dbl_nxt[MW-1:0];
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          acc_r <= add_nxt[MW-1:0];
          b_r   <= {b_r[MW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_DBL;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/rkm_egcd.sv =====
`timescale 1ns / 1ps
// Extended Euclid unit: gcd test of a against m and the inverse of a modulo m.
// Each division runs shift-and-subtract, one quotient bit per cycle. No dependencies.
module rkm_egcd #(
  parameter int MW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [MW-1:0] m,
  input  logic [MW-1:0] a,
  output logic          done,
  output logic          coprime,
  output logic [MW-1:0] inv
);

  localparam int XW = MW + 3;
  localparam int KW = $clog2(MW + 2);

  typedef enum logic [1:0] {ST_IDLE, ST_TEST, ST_ALIGN, ST_SUB} state_t;

  state_t               state_r;
  logic [MW-1:0]        m_r, r0_r, r1_r, rr_r;
  logic signed [XW-1:0] x0_r, x1_r, xx_r, dx_r;
  logic [MW:0]          dr_r;
  logic [KW-1:0]        k_r;
  logic                 done_r, coprime_r;
  logic [MW-1:0]        inv_r;
  logic [MW:0]          dh;
  logic signed [XW-1:0] dxh, x0_fix;

  always_comb begin
    dh     = dr_r >> 1;
    dxh    = dx_r >>> 1;
    x0_fix = x0_r[XW-1] ? x0_r + XW'(m_r) : x0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            m_r     <= m;
            r0_r    <= m;
            r1_r    <= a;
            x0_r    <= '0;
            x1_r    <= XW'(1);
            state_r <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (r1_r == '0) begin
            coprime_r <= (r0_r == MW'(1));
            inv_r     <= x0_fix[MW-1:0];
            done_r    <= 1'b1;
            state_r   <= ST_IDLE;
          end else begin
            rr_r    <= r0_r;
            xx_r    <= x0_r;
            dr_r    <= {1'b0, r1_r};
            dx_r    <= x1_r;
            k_r     <= '0;
            state_r <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (dr_r <= {1'b0, rr_r}) begin
            dr_r <= {dr_r[MW-1:0], 1'b0};
            dx_r <= dx_r <<< 1;
            k_r  <= k_r + 1'b1;
          end else begin
            state_r <= ST_SUB;
          end
        end
        ST_SUB: begin
          if (k_r == '0) begin
            r0_r    <= r1_r;
            r1_r    <= rr_r;
            x0_r    <= x1_r;
            x1_r    <= xx_r;
            state_r <= ST_TEST;
          end else begin
            dr_r <= dh;
            dx_r <= dxh;
            k_r  <= k_r - 1'b1;
            if (dh <= {1'b0, rr_r}) begin
              rr_r <= rr_r - dh[MW-1:0];
              xx_r <= xx_r - dxh;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign coprime = coprime_r;
  assign inv     = inv_r;

endmodule

// ===== rtl/rsa_keygen_and_modexp.sv =====
`timescale 1ns / 1ps
// Top level of the RSA key derivation and modular exponentiation block.
// Depends on rkm_pkg, rkm_egcd and rkm_mulmod.
//
// Usage: write prime_p (index 0) and prime_q (index 1) through the cfg_ port
// while the block is idle. Each input word carries func (0 encrypt with e,
// 1 decrypt with d) and value. The block derives n, the totient, e and d
// for every word, then returns value raised to the chosen exponent mod n,
// or a zero result with zero exponents and status set for a bad key. One
// word is worked on at a time; in_stall is high from acceptance until the
// result is loaded into the output register. Work runs in order: the two
// serial products, then the key search, in which each candidate e costs one
// extended Euclid run, then the reduction of value mod n, then up to
// 2*MOD_BITS modular multiplications on one shared bit-serial multiplier.
// The output register holds its word while out_stall is high; the next
// input word may be accepted while it waits.
// Reset clears the primes to zero and empties the output register.
module rsa_keygen_and_modexp #(
  parameter int MOD_BITS   = 32,
  parameter int PRIME_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rkm_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rkm_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [rkm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [PRIME_BITS-1:0]            cfg_wdata
);

  localparam int MW = MOD_BITS;
  localparam int CW = $clog2(PRIME_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_CHECK, ST_EGCD, ST_REDUCE, ST_EXP, ST_MUL, ST_SQR, ST_FIN
  } state_t;

  state_t                        state_r;
  logic [PRIME_BITS-1:0]         p_r, q_r, qa_r, qt_r;
  logic [MW-1:0]                 pa_r, pt_r, n_r, t_r, e_r, d_r, base_r, acc_r, ex_r;
  logic [CW-1:0]                 cnt_r;
  logic [rkm_pkg::RCNT_W-1:0]    rcnt_r;
  logic [rkm_pkg::VALUE_W-1:0]   val_r;
  logic                          func_r, bad_r;
  logic                          egcd_start_r, mul_start_r;
  logic                          out_valid_r;
  rkm_pkg::out_word_t            out_r;

  logic                          egcd_done, egcd_coprime;
  logic [MW-1:0]                 egcd_inv, mul_b, mul_prod;
  logic                          mul_done;
  logic [MW:0]                   red_s, red_nxt;
  logic                          key_bad;

  assign mul_b   = (state_r == ST_MUL) ? acc_r : base_r;
  assign key_bad = (t_r == '0) || (t_r == MW'(2)) || (n_r == '0);

  always_comb begin
    red_s   = {base_r, val_r[rkm_pkg::VALUE_W-1]};
    red_nxt = (red_s >= {1'b0, n_r}) ? red_s - {1'b0, n_r} : red_s;
  end

  rkm_egcd #(.MW(MW)) u_egcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (egcd_start_r),
    .m       (t_r),
    .a       (e_r),
    .done    (egcd_done),
    .coprime (egcd_coprime),
    .inv     (egcd_inv)
  );

  rkm_mulmod #(.MW(MW)) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (base_r),
    .b     (mul_b),
    .n     (n_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      p_r          <= '0;
      q_r          <= '0;
      egcd_start_r <= 1'b0;
      mul_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      egcd_start_r <= 1'b0;
      mul_start_r  <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          rkm_pkg::REG_PRIME_P: p_r <= cfg_wdata;
          rkm_pkg::REG_PRIME_Q: q_r <= cfg_wdata;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            func_r  <= in_data.func;
            val_r   <= in_data.value;
            pa_r    <= MW'(p_r);
            pt_r    <= MW'(p_r - 1'b1);
            qa_r    <= q_r;
            qt_r    <= (p_r == '0) ? '0 : q_r - 1'b1;
            n_r     <= '0;
            t_r     <= '0;
            cnt_r   <= CW'(PRIME_BITS);
            state_r <= ST_PROD;
          end
        end
        ST_PROD: begin
          if (qa_r[0]) begin
            n_r <= n_r + pa_r;
          end
          if (qt_r[0] && (q_r != '0)) begin
            t_r <= t_r + pt_r;
          end
          pa_r  <= {pa_r[MW-2:0], 1'b0};
          pt_r  <= {pt_r[MW-2:0], 1'b0};
          qa_r  <= qa_r >> 1;
          qt_r  <= qt_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          bad_r  <= key_bad;
          e_r    <= MW'(2);
          acc_r  <= (n_r == MW'(1)) ? '0 : MW'(1);
          base_r <= '0;
          rcnt_r <= rkm_pkg::RCNT_W'(rkm_pkg::VALUE_W);
          if (key_bad) begin
            e_r     <= '0;
            d_r     <= '0;
            state_r <= ST_FIN;
          end else if (t_r == MW'(1)) begin
            d_r     <= MW'(1);
            state_r <= ST_REDUCE;
          end else begin
            egcd_start_r <= 1'b1;
            state_r      <= ST_EGCD;
          end
        end
        ST_EGCD: begin
          if (egcd_done) begin
            if (egcd_coprime) begin
              d_r     <= egcd_inv;
              state_r <= ST_REDUCE;
            end else begin
              e_r          <= e_r + 1'b1;
              egcd_start_r <= 1'b1;
            end
          end
        end
        ST_REDUCE: begin
          base_r <= red_nxt[MW-1:0];
          val_r  <= {val_r[rkm_pkg::VALUE_W-2:0], 1'b0};
          rcnt_r <= rcnt_r - 1'b1;
          if (rcnt_r == rkm_pkg::RCNT_W'(1)) begin
            ex_r    <= func_r ? d_r : e_r;
            state_r <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (ex_r == '0) begin
            state_r <= ST_FIN;
          end else if (ex_r[0]) begin
            mul_start_r <= 1'b1;
            state_r     <= ST_MUL;
          end else begin
            mul_start_r <= 1'b1;
            state_r     <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            acc_r       <= mul_prod;
            mul_start_r <= 1'b1;
            state_r     <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (mul_done) begin
            base_r  <= mul_prod;
            ex_r    <= ex_r >> 1;
            state_r <= ST_EXP;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_r.result           <= bad_r ? '0 : rkm_pkg::WORD_W'(acc_r);
            out_r.public_exponent  <= rkm_pkg::WORD_W'(e_r);
            out_r.private_exponent <= rkm_pkg::WORD_W'(d_r);
            out_r.modulus          <= rkm_pkg::WORD_W'(n_r);
            out_r.status           <= bad_r;
            out_valid_r            <= 1'b1;
            state_r                <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("output word appeared outside the finish step");

  a_bad_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status) |->
      (out_r.result == '0 && out_r.public_exponent == '0 && out_r.private_exponent == '0))
    else $error("bad key word carries nonzero exponents or result");

  a_result_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.status) |-> (out_r.result < out_r.modulus))
    else $error("result not reduced below the modulus");
`endif

endmodule
